// ===== sv/ias_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ias_pkg: shared definitions for the indexed array store
// Storage sizes, field widths, command and status codes, and the per-cell
// control word that travels from the controller to the cell chain.
// ----------------------------------------------------------------------------
package ias_pkg;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;

    // Fixed widths of the interface fields.
    localparam int CMD_W       = 2;
    localparam int INDEX_W     = 4;
    localparam int VALUE_W     = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 2;

    // Internal widths derived from the storage size.
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    typedef logic [WORD_WIDTH-1:0] word_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_INSERT = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // load: take the incoming word; shift: take the word of the lower neighbour.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// ===== sv/ias_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ias_cell: one storage cell of the array chain
// Holds one element word. It either loads the new word, takes the word of
// its lower neighbour during an insert, or keeps its contents.
// ----------------------------------------------------------------------------
module ias_cell (
    input  logic                clk,
    input  ias_pkg::cell_ctrl_t ctrl,
    input  ias_pkg::word_t      left_word,
    input  ias_pkg::word_t      new_word,
    output ias_pkg::word_t      word
);

    ias_pkg::word_t word_reg;
    ias_pkg::word_t word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.load)
        begin
            word_next = new_word;
        end
        else if (ctrl.shift)
        begin
            word_next = left_word;
        end
    end

    // Element contents are undefined until written, so the cell has no reset.
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== sv/indexed_array_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_array_store: fixed-capacity ordered array of words
// Push, pop, insert at index and read at index over a chain of cells.
// ----------------------------------------------------------------------------
// The block takes one command in every clock cycle: busy never rises, and
// each result appears on the result ports, marked by done, in the cycle
// after its command was transferred and for that cycle only. An insert moves
// every element above the index up by one cell in that same cycle, since each
// cell of the chain loads its lower neighbour in parallel; the single read
// selector over the cells serves both pop and read. No clearing pass follows
// reset: the element count is cleared and entries beyond it are never read.
// ----------------------------------------------------------------------------
module indexed_array_store (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ias_pkg::CMD_W-1:0]           command,
    input  logic [ias_pkg::INDEX_W-1:0]         index,
    input  logic signed [ias_pkg::VALUE_W-1:0]  value,
    output logic                                done,
    output logic signed [ias_pkg::VALUE_W-1:0]  read_value,
    output logic [ias_pkg::COUNT_OUT_W-1:0]     element_count,
    output logic [ias_pkg::STATUS_W-1:0]        status
);

    logic [ias_pkg::CNT_W-1:0]   count_reg;
    logic [ias_pkg::CNT_W-1:0]   count_next;
    logic                        done_reg;
    logic [ias_pkg::VALUE_W-1:0] res_value_reg;
    logic [ias_pkg::VALUE_W-1:0] res_value_next;
    logic [ias_pkg::CNT_W-1:0]   res_count_reg;
    ias_pkg::status_t            res_status_reg;
    ias_pkg::status_t            res_status_next;

    logic                        accept;
    logic                        full;
    logic                        empty;
    logic                        push_ok;
    logic                        pop_ok;
    logic                        ins_ok;
    logic                        rd_ok;
    logic [ias_pkg::CMP_W-1:0]   cnt_ext;
    logic [ias_pkg::CMP_W-1:0]   pos_ext;
    logic [ias_pkg::CNT_W-1:0]   cnt_dec;
    logic [ias_pkg::ADDR_W-1:0]  rd_addr;
    logic [ias_pkg::ADDR_W-1:0]  pos_addr;
    logic [ias_pkg::ADDR_W-1:0]  tail_addr;
    ias_pkg::word_t              new_word;
    ias_pkg::word_t              rd_word;
    ias_pkg::word_t              cell_word [ias_pkg::DEPTH];
    ias_pkg::cell_ctrl_t         cell_ctrl [ias_pkg::DEPTH];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign cnt_ext  = ias_pkg::CMP_W'(count_reg);
    assign pos_ext  = ias_pkg::CMP_W'(index);
    assign full     = (count_reg == ias_pkg::CNT_W'(ias_pkg::DEPTH));
    assign empty    = (count_reg == '0);
    assign cnt_dec  = count_reg - ias_pkg::CNT_W'(1);
    assign pos_addr = pos_ext[ias_pkg::ADDR_W-1:0];
    assign tail_addr = count_reg[ias_pkg::ADDR_W-1:0];
    assign new_word = ias_pkg::WORD_WIDTH'($unsigned(value));

    always_comb
    begin
        push_ok         = 1'b0;
        pop_ok          = 1'b0;
        ins_ok          = 1'b0;
        rd_ok           = 1'b0;
        res_status_next = ias_pkg::ST_OK;
        rd_addr         = pos_addr;
        case (ias_pkg::cmd_t'(command))
            ias_pkg::CMD_PUSH:
            begin
                if (full)
                begin
                    res_status_next = ias_pkg::ST_FULL;
                end
                else
                begin
                    push_ok = 1'b1;
                end
            end
            ias_pkg::CMD_POP:
            begin
                rd_addr = cnt_dec[ias_pkg::ADDR_W-1:0];
                if (empty)
                begin
                    res_status_next = ias_pkg::ST_EMPTY;
                end
                else
                begin
                    pop_ok = 1'b1;
                end
            end
            ias_pkg::CMD_INSERT:
            begin
                // The full check takes precedence over the index check.
                if (full)
                begin
                    res_status_next = ias_pkg::ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    res_status_next = ias_pkg::ST_RANGE;
                end
                else
                begin
                    ins_ok = 1'b1;
                end
            end
            default:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    res_status_next = ias_pkg::ST_RANGE;
                end
                else
                begin
                    rd_ok = 1'b1;
                end
            end
        endcase
    end

    assign rd_word        = cell_word[rd_addr];
    assign res_value_next = (pop_ok || rd_ok) ? ias_pkg::VALUE_W'(rd_word) : '0;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (push_ok || ins_ok)
            begin
                count_next = count_reg + ias_pkg::CNT_W'(1);
            end
            else if (pop_ok)
            begin
                count_next = cnt_dec;
            end
        end
    end

    // Cell k loads the new word when it is the target of a push or insert,
    // and takes its lower neighbour's word when it lies above an insert point.
    for (genvar k = 0; k < ias_pkg::DEPTH; k++)
    begin : g_cell
        localparam logic [ias_pkg::ADDR_W-1:0] CELL_ADDR = ias_pkg::ADDR_W'(k);

        assign cell_ctrl[k].load  = accept && ((push_ok && (tail_addr == CELL_ADDR)) ||
                                               (ins_ok && (pos_addr == CELL_ADDR)));
        assign cell_ctrl[k].shift = accept && ins_ok && (CELL_ADDR > pos_addr);

        if (k == 0)
        begin : g_first
            ias_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[k]),
                .left_word (new_word),
                .new_word  (new_word),
                .word      (cell_word[k])
            );
        end
        else
        begin : g_rest
            ias_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl[k]),
                .left_word (cell_word[k-1]),
                .new_word  (new_word),
                .word      (cell_word[k])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_value_reg  <= res_value_next;
            res_count_reg  <= count_next;
            res_status_reg <= res_status_next;
        end
    end

    assign done          = done_reg;
    assign read_value    = res_value_reg;
    assign element_count = ias_pkg::COUNT_OUT_W'(res_count_reg);
    assign status        = res_status_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ias_pkg::CNT_W'(ias_pkg::DEPTH))
    else $error("element count exceeds the array depth");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
    else $error("accepted command produced no result");

    a_refused_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (res_status_next != ias_pkg::ST_OK)) |=> (count_reg == $past(count_reg)))
    else $error("refused command changed the element count");

    a_result_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (res_count_reg == count_reg))
    else $error("reported element count differs from the stored count");
`endif

endmodule

// ===== tb/tb_indexed_array_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_array_store: self-checking testbench for the indexed array store
// A short table of directed commands covers the empty and full array, both
// ends of the index and word ranges, and every refusal. Randomised phases
// then fill, drain and churn the array, mostly with gaps between commands.
// Every result is checked against its pinned row or a behavioural copy of the array.
// ----------------------------------------------------------------------------
module tb_indexed_array_store;

    localparam int RANDOM_ITEMS = 1000;
    localparam int QUIET_LIMIT  = 500;
    localparam int PLAN_ROWS    = 25;

    typedef struct packed {
        logic [ias_pkg::VALUE_W-1:0]     rd;
        logic [ias_pkg::COUNT_OUT_W-1:0] cnt;
        ias_pkg::status_t                st;
    } array_result_t;

    // One row of the directed plan; a pinned row carries its expected result.
    typedef struct packed {
        ias_pkg::cmd_t                   cmd;
        logic [ias_pkg::INDEX_W-1:0]     idx;
        logic [ias_pkg::VALUE_W-1:0]     val;
        logic [4:0]                      reps;
        logic                            pinned;
        logic [ias_pkg::VALUE_W-1:0]     rd;
        logic [ias_pkg::COUNT_OUT_W-1:0] cnt;
        ias_pkg::status_t                st;
    } plan_row_t;

    typedef enum int {
        FILL_UP,
        DRAIN_DOWN,
        CHURN
    } phase_bias_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 start;
    logic                                 busy;
    logic [ias_pkg::CMD_W-1:0]            command;
    logic [ias_pkg::INDEX_W-1:0]          index;
    logic signed [ias_pkg::VALUE_W-1:0]   value;
    logic                                 done;
    logic signed [ias_pkg::VALUE_W-1:0]   read_value;
    logic [ias_pkg::COUNT_OUT_W-1:0]      element_count;
    logic [ias_pkg::STATUS_W-1:0]         status;

    // Expected result for pinned directed rows, driven alongside the command.
    logic                                 pin_valid;
    logic [ias_pkg::VALUE_W-1:0]          pin_read;
    logic [ias_pkg::COUNT_OUT_W-1:0]      pin_count;
    ias_pkg::status_t                     pin_status;

    ias_pkg::word_t                       shadow_words [ias_pkg::DEPTH];
    int                                   shadow_count = 0;
    int                                   fill_level = 0;
    array_result_t                        pending_results [$];
    int                                   mismatch_count = 0;
    int                                   quiet_cycles = 0;
    int                                   items_sent = 0;
    bit                                   steady_flow = 1'b0;

    plan_row_t directed_plan [PLAN_ROWS] = '{
        '{ias_pkg::CMD_POP,    4'd0,  32'h0000_0000, 5'd1,
          1'b1, 32'h0000_0000, 5'd0,  ias_pkg::ST_EMPTY},
        '{ias_pkg::CMD_READ,   4'd0,  32'h0000_0000, 5'd1,
          1'b1, 32'h0000_0000, 5'd0,  ias_pkg::ST_RANGE},
        '{ias_pkg::CMD_INSERT, 4'd1,  32'h1111_1111, 5'd1,
          1'b1, 32'h0000_0000, 5'd0,  ias_pkg::ST_RANGE},
        '{ias_pkg::CMD_INSERT, 4'd0,  32'h7FFF_FFFF, 5'd1,
          1'b1, 32'h0000_0000, 5'd1,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_PUSH,   4'd9,  32'h8000_0000, 5'd1,
          1'b1, 32'h0000_0000, 5'd2,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_INSERT, 4'd1,  32'hFFFF_FFFF, 5'd1,
          1'b1, 32'h0000_0000, 5'd3,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_READ,   4'd0,  32'h0000_0000, 5'd1,
          1'b1, 32'h7FFF_FFFF, 5'd3,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_READ,   4'd1,  32'h0000_0000, 5'd1,
          1'b1, 32'hFFFF_FFFF, 5'd3,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_READ,   4'd2,  32'h0000_0000, 5'd1,
          1'b1, 32'h8000_0000, 5'd3,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_READ,   4'd3,  32'h0000_0000, 5'd1,
          1'b1, 32'h0000_0000, 5'd3,  ias_pkg::ST_RANGE},
        '{ias_pkg::CMD_INSERT, 4'd3,  32'h1234_5678, 5'd1,
          1'b1, 32'h0000_0000, 5'd4,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_INSERT, 4'd15, 32'hDEAD_BEEF, 5'd1,
          1'b1, 32'h0000_0000, 5'd4,  ias_pkg::ST_RANGE},
        '{ias_pkg::CMD_POP,    4'd7,  32'h0000_0000, 5'd1,
          1'b1, 32'h1234_5678, 5'd3,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_PUSH,   4'd0,  32'h0000_0100, 5'd13,
          1'b0, 32'h0000_0000, 5'd0,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_PUSH,   4'd0,  32'hCAFE_0001, 5'd1,
          1'b1, 32'h0000_0000, 5'd16, ias_pkg::ST_FULL},
        '{ias_pkg::CMD_INSERT, 4'd0,  32'hCAFE_0002, 5'd1,
          1'b1, 32'h0000_0000, 5'd16, ias_pkg::ST_FULL},
        '{ias_pkg::CMD_INSERT, 4'd15, 32'hCAFE_0003, 5'd1,
          1'b1, 32'h0000_0000, 5'd16, ias_pkg::ST_FULL},
        '{ias_pkg::CMD_READ,   4'd15, 32'h0000_0000, 5'd1,
          1'b0, 32'h0000_0000, 5'd0,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_READ,   4'd0,  32'h0000_0000, 5'd1,
          1'b1, 32'h7FFF_FFFF, 5'd16, ias_pkg::ST_OK},
        '{ias_pkg::CMD_POP,    4'd0,  32'h0000_0000, 5'd1,
          1'b0, 32'h0000_0000, 5'd0,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_INSERT, 4'd0,  32'h5A5A_5A5A, 5'd1,
          1'b1, 32'h0000_0000, 5'd16, ias_pkg::ST_OK},
        '{ias_pkg::CMD_READ,   4'd1,  32'h0000_0000, 5'd1,
          1'b1, 32'h7FFF_FFFF, 5'd16, ias_pkg::ST_OK},
        '{ias_pkg::CMD_POP,    4'd0,  32'h0000_0000, 5'd16,
          1'b0, 32'h0000_0000, 5'd0,  ias_pkg::ST_OK},
        '{ias_pkg::CMD_POP,    4'd3,  32'h0000_0000, 5'd1,
          1'b1, 32'h0000_0000, 5'd0,  ias_pkg::ST_EMPTY},
        '{ias_pkg::CMD_READ,   4'd15, 32'h0000_0000, 5'd1,
          1'b1, 32'h0000_0000, 5'd0,  ias_pkg::ST_RANGE}
    };

    indexed_array_store DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .index         (index),
        .value         (value),
        .done          (done),
        .read_value    (read_value),
        .element_count (element_count),
        .status        (status)
    );

    always #6 clk = ~clk;

    // Applies one command to the local copy of the array and returns its result.
    function automatic array_result_t apply_command(ias_pkg::cmd_t op,
                                                    logic [ias_pkg::INDEX_W-1:0] idx,
                                                    logic [ias_pkg::VALUE_W-1:0] word);
        array_result_t res;
        int            pos;
        int            k;
        res = '{rd: '0, cnt: '0, st: ias_pkg::ST_OK};
        pos = int'(idx);
        case (op)
            ias_pkg::CMD_PUSH:
            begin
                if (shadow_count >= ias_pkg::DEPTH)
                    res.st = ias_pkg::ST_FULL;
                else
                begin
                    shadow_words[shadow_count] = ias_pkg::word_t'(word);
                    shadow_count++;
                end
            end
            ias_pkg::CMD_POP:
            begin
                if (shadow_count == 0)
                    res.st = ias_pkg::ST_EMPTY;
                else
                begin
                    shadow_count--;
                    res.rd = ias_pkg::VALUE_W'(shadow_words[shadow_count]);
                end
            end
            ias_pkg::CMD_INSERT:
            begin
                // A full array is refused before the index is looked at.
                if (shadow_count >= ias_pkg::DEPTH)
                    res.st = ias_pkg::ST_FULL;
                else if (pos > shadow_count)
                    res.st = ias_pkg::ST_RANGE;
                else
                begin
                    for (k = shadow_count; k > pos; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[pos] = ias_pkg::word_t'(word);
                    shadow_count++;
                end
            end
            default:
            begin
                if (pos >= shadow_count)
                    res.st = ias_pkg::ST_RANGE;
                else
                    res.rd = ias_pkg::VALUE_W'(shadow_words[pos]);
            end
        endcase
        res.cnt = ias_pkg::COUNT_OUT_W'(shadow_count);
        return res;
    endfunction

    task automatic flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Predicts on every command transfer and checks every result strobe.
    always @(posedge clk)
    begin
        array_result_t predicted;
        array_result_t wanted;
        if (rst_n)
        begin
            if (start && busy === 1'b0)
            begin
                predicted = apply_command(ias_pkg::cmd_t'(command), index, value);
                if (pin_valid)
                    predicted = '{rd: pin_read, cnt: pin_count, st: pin_status};
                pending_results = {pending_results, predicted};
            end
            if (done)
            begin
                if (pending_results.size() == 0)
                    flag_error($sformatf("unexpected result: read_value=%h count=%0d status=%0d",
                                         read_value, element_count, status));
                else
                begin
                    wanted = pending_results.pop_front();
                    if (read_value !== wanted.rd || element_count !== wanted.cnt
                        || status !== wanted.st)
                        flag_error($sformatf({"result mismatch: expected read_value=%h ",
                                              "count=%0d status=%0d, got read_value=%h ",
                                              "count=%0d status=%0d"},
                                             wanted.rd, wanted.cnt, wanted.st,
                                             read_value, element_count, status));
                end
            end
            fill_level <= shadow_count;
        end
        if ((start && busy === 1'b0) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Holds the command for as long as the block is busy; returns after the transfer.
    task automatic send_command(input ias_pkg::cmd_t op,
                                input logic [ias_pkg::INDEX_W-1:0] idx,
                                input logic [ias_pkg::VALUE_W-1:0] word, input logic pinned,
                                input logic [ias_pkg::VALUE_W-1:0] exp_rd,
                                input logic [ias_pkg::COUNT_OUT_W-1:0] exp_cnt,
                                input ias_pkg::status_t exp_st);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        command    <= op;
        index      <= idx;
        value      <= word;
        pin_valid  <= pinned;
        pin_read   <= exp_rd;
        pin_count  <= exp_cnt;
        pin_status <= exp_st;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_until_settled();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [ias_pkg::VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return ias_pkg::VALUE_W'($urandom);
        endcase
    endfunction

    function automatic ias_pkg::cmd_t pick_command(phase_bias_t bias);
        int roll;
        roll = $urandom_range(0, 99);
        case (bias)
            FILL_UP:
                return (roll < 40) ? ias_pkg::CMD_PUSH : (roll < 75) ? ias_pkg::CMD_INSERT :
                       (roll < 90) ? ias_pkg::CMD_READ : ias_pkg::CMD_POP;
            DRAIN_DOWN:
                return (roll < 55) ? ias_pkg::CMD_POP : (roll < 80) ? ias_pkg::CMD_READ :
                       (roll < 90) ? ias_pkg::CMD_PUSH : ias_pkg::CMD_INSERT;
            default:
                return ias_pkg::cmd_t'(roll % 4);
        endcase
    endfunction

    // Most insert and read indices fall inside the stored range; the rest are anywhere in the field.
    task automatic run_random_phase(input int len, input phase_bias_t bias);
        ias_pkg::cmd_t               op;
        logic [ias_pkg::INDEX_W-1:0] idx;
        int                          lvl;
        int                          i;
        for (i = 0; i < len; i++)
        begin
            op  = pick_command(bias);
            lvl = fill_level;
            if ($urandom_range(0, 4) == 0)
                idx = ias_pkg::INDEX_W'($urandom_range(0, 15));
            else if (op == ias_pkg::CMD_INSERT)
                idx = (lvl > 15) ? 4'd15 : ias_pkg::INDEX_W'($urandom_range(0, lvl));
            else if (op == ias_pkg::CMD_READ && lvl > 0)
                idx = ias_pkg::INDEX_W'($urandom_range(0, (lvl > 16 ? 16 : lvl) - 1));
            else
                idx = ias_pkg::INDEX_W'($urandom_range(0, 15));
            send_command(op, idx, pick_word(), 1'b0, '0, '0, ias_pkg::ST_OK);
        end
    endtask

    initial
    begin
        int          r;
        int          k;
        int          phase_no;
        int          random_target;
        phase_bias_t bias;

        rst_n      = 1'b0;
        start      = 1'b0;
        command    = ias_pkg::CMD_PUSH;
        index      = '0;
        value      = '0;
        pin_valid  = 1'b0;
        pin_read   = '0;
        pin_count  = '0;
        pin_status = ias_pkg::ST_OK;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < PLAN_ROWS; r++)
            for (k = 0; k < int'(directed_plan[r].reps); k++)
                send_command(directed_plan[r].cmd, directed_plan[r].idx,
                             directed_plan[r].val + ias_pkg::VALUE_W'(k),
                             directed_plan[r].pinned,
                             directed_plan[r].rd, directed_plan[r].cnt, directed_plan[r].st);

        wait_until_settled();

        random_target = items_sent + RANDOM_ITEMS;
        phase_no = 0;
        while (items_sent < random_target)
        begin
            phase_no++;
            steady_flow = ($urandom_range(0, 3) == 0);
            bias = phase_bias_t'($urandom_range(0, 2));
            run_random_phase($urandom_range(20, 60), bias);
            if (phase_no % 5 == 0)
                wait_until_settled();
        end

        wait_until_settled();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
